[rtl/core/qau_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

    // Default component format: signed Q16.16.
    localparam int COMPONENT_WIDTH_DEF = 32;
    localparam int FRACTION_BITS_DEF   = 16;

    // Number of quaternion components.
    localparam int LANES = 4;

    // Minus signs of the Hamilton product, bit (row * 4 + term).
    // The second operand of term k in row i is component (i xor k).
    localparam logic [15:0] HAM_MINUS = 16'h428E;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_NEG   = 4'd2,
        OP_SCALE = 4'd3,
        OP_MUL   = 4'd4,
        OP_CONJ  = 4'd5,
        OP_DOT   = 4'd6,
        OP_NORM  = 4'd7,
        OP_NORMZ = 4'd8,
        OP_INV   = 4'd9
    } op_t;

    // Control that travels alongside each item through the pipeline.
    typedef struct packed {
        logic valid;
        op_t  op;
        logic ovf;
        logic zn;
    } ctrl_t;

endpackage

`default_nettype wire

[rtl/core/quaternion_arithmetic_unit.sv]
// The pipeline depth grows with COMPONENT_WIDTH (Q16.16 by default) and is set by the
// square-root chain (one root bit per cell) followed by the divider chain (one quotient
// bit per cell, four lanes in each cell). Throughput: one item per cycle while the
// output is not stalled; every opcode passes through the same pipeline.
// Reset (rst_n, asynchronous, active low) clears all valid bits; data registers keep
// their contents and are ignored until an item reaches them.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arithmetic_unit #(
    parameter int COMPONENT_WIDTH = qau_pkg::COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = qau_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [3:0]                        op,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_w,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_z,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_w,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_z,
    input  wire logic signed [COMPONENT_WIDTH-1:0] factor,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [COMPONENT_WIDTH-1:0]      r_w,
    output logic signed [COMPONENT_WIDTH-1:0]      r_x,
    output logic signed [COMPONENT_WIDTH-1:0]      r_y,
    output logic signed [COMPONENT_WIDTH-1:0]      r_z,
    output logic signed [COMPONENT_WIDTH-1:0]      scalar_out,
    output logic                                   overflow,
    output logic                                   zero_norm
);

    localparam int W  = COMPONENT_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int L  = qau_pkg::LANES;
    localparam int NW = W + 2 * F;
    localparam int XW = 2 * W + 2 * F;

    logic                en;
    logic signed [W-1:0] a_vec [L];
    logic signed [W-1:0] b_vec [L];

    qau_pkg::ctrl_t      fr_ctrl;
    logic signed [W-1:0] fr_r [L];
    logic signed [W-1:0] fr_sc;
    logic [2*W-1:0]      fr_ssq;

    // Square-root chain and the items riding alongside it.
    logic [W:0]          sq_rem  [W+1];
    logic [W-1:0]        sq_root [W+1];
    logic [2*W-1:0]      sq_rad  [W+1];
    qau_pkg::ctrl_t      sp_ctrl_reg [W];
    logic signed [W-1:0] sp_r_reg [W][L];
    logic signed [W-1:0] sp_sc_reg [W];
    logic [2*W-1:0]      sp_ssq_reg [W];

    // Divider set-up stage.
    qau_pkg::ctrl_t      dv_ctrl_reg, dv_ctrl_next;
    logic signed [W-1:0] dv_r_reg [L];
    logic signed [W-1:0] dv_sc_reg, dv_sc_next;
    logic [L-1:0]        dv_big_reg, dv_big_next;
    logic [2*W-1:0]      dv_den_reg, dv_den_next;
    logic [2*W-1:0]      dv_rem_reg [L];
    logic [2*W-1:0]      dv_rem_next [L];
    logic [W-1:0]        dv_nlo_reg [L];
    logic [W-1:0]        dv_nlo_next [L];
    logic [W-1:0]        dv_mag [L];
    logic [NW-1:0]       dv_num [L];
    logic [XW-1:0]       dv_hi [L];
    logic [XW-1:0]       dv_den_x;
    qau_pkg::op_t        dv_op;

    // Divider chain and the items riding alongside it.
    logic [2*W-1:0]      dc_den [W+1];
    logic [2*W-1:0]      dc_rem [W+1][L];
    logic [W-1:0]        dc_nlo [W+1][L];
    logic [W-1:0]        dc_quo [W+1][L];
    qau_pkg::ctrl_t      dp_ctrl_reg [W];
    logic signed [W-1:0] dp_r_reg [W][L];
    logic signed [W-1:0] dp_sc_reg [W];
    logic [L-1:0]        dp_big_reg [W];

    // Output register.
    logic                out_valid_reg;
    logic signed [W-1:0] out_r_reg [L];
    logic signed [W-1:0] out_r_next [L];
    logic signed [W-1:0] out_sc_reg, out_sc_next;
    logic                out_ovf_reg, out_ovf_next;
    logic                out_zn_reg;
    qau_pkg::ctrl_t      fin_ctrl;
    logic                fin_neg;
    logic [W-1:0]        fin_lim;
    logic [W-1:0]        fin_q;

    // The whole pipeline advances unless a finished item is held at the output.
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    assign a_vec[0] = a_w;
    assign a_vec[1] = a_x;
    assign a_vec[2] = a_y;
    assign a_vec[3] = a_z;
    assign b_vec[0] = b_w;
    assign b_vec[1] = b_x;
    assign b_vec[2] = b_y;
    assign b_vec[3] = b_z;

    qau_front #(
        .W (W),
        .F (F)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .accept (in_valid),
        .op     (op),
        .a      (a_vec),
        .b      (b_vec),
        .f      (factor),
        .ctrl   (fr_ctrl),
        .r      (fr_r),
        .sc     (fr_sc),
        .ssq    (fr_ssq)
    );

    // Square root of the sum of squares, one root bit per cell.
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = fr_ssq;

    for (genvar j = 0; j < W; j++)
    begin : g_sqrt
        qau_sqrt_cell #(
            .W (W)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (sq_rem[j]),
            .root_in  (sq_root[j]),
            .rad_in   (sq_rad[j]),
            .rem_out  (sq_rem[j+1]),
            .root_out (sq_root[j+1]),
            .rad_out  (sq_rad[j+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < W; j++)
            begin
                sp_ctrl_reg[j] <= '0;
                dp_ctrl_reg[j] <= '0;
            end
            dv_ctrl_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sp_ctrl_reg[0] <= fr_ctrl;
            dp_ctrl_reg[0] <= dv_ctrl_reg;
            for (int j = 1; j < W; j++)
            begin
                sp_ctrl_reg[j] <= sp_ctrl_reg[j-1];
                dp_ctrl_reg[j] <= dp_ctrl_reg[j-1];
            end
            dv_ctrl_reg   <= dv_ctrl_next;
            out_valid_reg <= dp_ctrl_reg[W-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_r_reg[0]   <= fr_r;
            sp_sc_reg[0]  <= fr_sc;
            sp_ssq_reg[0] <= fr_ssq;
            dp_r_reg[0]   <= dv_r_reg;
            dp_sc_reg[0]  <= dv_sc_reg;
            dp_big_reg[0] <= dv_big_reg;
            for (int j = 1; j < W; j++)
            begin
                sp_r_reg[j]   <= sp_r_reg[j-1];
                sp_sc_reg[j]  <= sp_sc_reg[j-1];
                sp_ssq_reg[j] <= sp_ssq_reg[j-1];
                dp_r_reg[j]   <= dp_r_reg[j-1];
                dp_sc_reg[j]  <= dp_sc_reg[j-1];
                dp_big_reg[j] <= dp_big_reg[j-1];
            end
            dv_r_reg    <= sp_r_reg[W-1];
            dv_sc_reg   <= dv_sc_next;
            dv_big_reg  <= dv_big_next;
            dv_den_reg  <= dv_den_next;
            dv_rem_reg  <= dv_rem_next;
            dv_nlo_reg  <= dv_nlo_next;
            out_r_reg   <= out_r_next;
            out_sc_reg  <= out_sc_next;
            out_ovf_reg <= out_ovf_next;
            out_zn_reg  <= dp_ctrl_reg[W-1].zn;
        end
    end

    // Divider set-up: norm result, zero-norm check, dividend and divisor.
    // A quotient of 2^W or more is caught here and only saturates later.
    always_comb
    begin
        dv_op             = sp_ctrl_reg[W-1].op;
        dv_ctrl_next      = sp_ctrl_reg[W-1];
        dv_ctrl_next.zn   = (sp_ssq_reg[W-1] == '0) &&
                            (dv_op == qau_pkg::OP_NORMZ || dv_op == qau_pkg::OP_INV);
        dv_sc_next        = sp_sc_reg[W-1];
        if (dv_op == qau_pkg::OP_NORM)
        begin
            if (sq_root[W] > {1'b0, {(W-1){1'b1}}})
            begin
                dv_ctrl_next.ovf = 1'b1;
                dv_sc_next       = {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                dv_sc_next = sq_root[W];
            end
        end
        dv_den_next = (dv_op == qau_pkg::OP_INV) ? sp_ssq_reg[W-1] : {{W{1'b0}}, sq_root[W]};
        dv_den_x    = {{(2*F){1'b0}}, dv_den_next};
        for (int i = 0; i < L; i++)
        begin
            dv_mag[i] = sp_r_reg[W-1][i][W-1] ? -sp_r_reg[W-1][i] : sp_r_reg[W-1][i];
            if (dv_op == qau_pkg::OP_INV)
            begin
                dv_num[i] = {{(2*F){1'b0}}, dv_mag[i]} << (2 * F);
            end
            else
            begin
                dv_num[i] = {{(2*F){1'b0}}, dv_mag[i]} << F;
            end
            dv_hi[i]       = {{(2*W){1'b0}}, dv_num[i][NW-1:W]};
            dv_big_next[i] = dv_hi[i] >= dv_den_x;
            dv_rem_next[i] = dv_big_next[i] ? '0 : dv_hi[i][2*W-1:0];
            dv_nlo_next[i] = dv_num[i][W-1:0];
        end
    end

    // Four-lane division, one quotient bit per cell.
    assign dc_den[0] = dv_den_reg;
    assign dc_rem[0] = dv_rem_reg;
    assign dc_nlo[0] = dv_nlo_reg;

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            dc_quo[0][i] = '0;
        end
    end

    for (genvar j = 0; j < W; j++)
    begin : g_div
        qau_div_cell #(
            .W (W)
        ) u_cell (
            .clk     (clk),
            .en      (en),
            .den_in  (dc_den[j]),
            .rem_in  (dc_rem[j]),
            .nlo_in  (dc_nlo[j]),
            .quo_in  (dc_quo[j]),
            .den_out (dc_den[j+1]),
            .rem_out (dc_rem[j+1]),
            .nlo_out (dc_nlo[j+1]),
            .quo_out (dc_quo[j+1])
        );
    end

    // Final selection: saturate quotients and apply the zero-norm cases.
    always_comb
    begin
        fin_ctrl     = dp_ctrl_reg[W-1];
        out_r_next   = dp_r_reg[W-1];
        out_sc_next  = dp_sc_reg[W-1];
        out_ovf_next = fin_ctrl.ovf;
        fin_neg      = 1'b0;
        fin_lim      = '0;
        fin_q        = '0;
        case (fin_ctrl.op)
            qau_pkg::OP_NORM:
            begin
                for (int i = 0; i < L; i++)
                begin
                    out_r_next[i] = '0;
                end
            end
            qau_pkg::OP_NORMZ, qau_pkg::OP_INV:
            begin
                if (fin_ctrl.zn)
                begin
                    if (fin_ctrl.op == qau_pkg::OP_INV)
                    begin
                        for (int i = 0; i < L; i++)
                        begin
                            out_r_next[i] = '0;
                        end
                    end
                end
                else
                begin
                    for (int i = 0; i < L; i++)
                    begin
                        fin_neg = dp_r_reg[W-1][i][W-1] ^
                                  (fin_ctrl.op == qau_pkg::OP_INV && i > 0);
                        fin_lim = fin_neg ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
                        fin_q   = dc_quo[W][i];
                        if (dp_big_reg[W-1][i] || fin_q > fin_lim)
                        begin
                            out_ovf_next = 1'b1;
                            fin_q        = fin_lim;
                        end
                        out_r_next[i] = fin_neg ? -fin_q : fin_q;
                    end
                end
            end
            default:
            begin
                out_ovf_next = fin_ctrl.ovf;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign r_w        = out_r_reg[0];
    assign r_x        = out_r_reg[1];
    assign r_y        = out_r_reg[2];
    assign r_z        = out_r_reg[3];
    assign scalar_out = out_sc_reg;
    assign overflow   = out_ovf_reg;
    assign zero_norm  = out_zn_reg;

    // A zero norm never comes with a saturated value.
    a_zn_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm |-> !overflow)
        else $error("zero_norm raised together with overflow");

    // A scalar result and a quaternion result never appear in the same item.
    a_scalar_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (scalar_out != '0) |->
            (r_w == '0) && (r_x == '0) && (r_y == '0) && (r_z == '0))
        else $error("scalar result with non-zero quaternion result");

    // The square-root remainder stays within twice the root.
    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sp_ctrl_reg[W-1].valid |-> (sq_rem[W] <= {sq_root[W], 1'b0}))
        else $error("square-root remainder out of range");

    // Every radicand and dividend bit has been consumed at the end of each chain.
    a_chains_done: assert property (@(posedge clk) disable iff (!rst_n)
        sp_ctrl_reg[W-1].valid && dp_ctrl_reg[W-1].valid |->
            (sq_rad[W] == '0) && (dc_nlo[W][0] == '0) && (dc_nlo[W][1] == '0) &&
            (dc_nlo[W][2] == '0) && (dc_nlo[W][3] == '0))
        else $error("chain did not consume all input bits");

    // A real division ends with a remainder below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dp_ctrl_reg[W-1].valid && !dp_ctrl_reg[W-1].zn && !dp_big_reg[W-1][0] &&
        (dp_ctrl_reg[W-1].op == qau_pkg::OP_NORMZ || dp_ctrl_reg[W-1].op == qau_pkg::OP_INV)
        |-> (dc_rem[W][0] < dc_den[W]))
        else $error("division remainder not below divisor");

endmodule

`default_nettype wire

[rtl/core/qau_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module qau_front #(
    parameter int W = qau_pkg::COMPONENT_WIDTH_DEF,
    parameter int F = qau_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                accept,
    input  wire logic [3:0]          op,
    input  wire logic signed [W-1:0] a [qau_pkg::LANES],
    input  wire logic signed [W-1:0] b [qau_pkg::LANES],
    input  wire logic signed [W-1:0] f,
    output qau_pkg::ctrl_t           ctrl,
    output logic signed [W-1:0]      r [qau_pkg::LANES],
    output logic signed [W-1:0]      sc,
    output logic [2*W-1:0]           ssq
);

    localparam int L  = qau_pkg::LANES;
    localparam int SW = 2 * W + 2;

    qau_pkg::ctrl_t c0_reg, c1_reg, c2_reg, c3_reg;
    qau_pkg::ctrl_t c0_next, c3_next;

    logic signed [W-1:0]    a0_reg [L];
    logic signed [W-1:0]    b0_reg [L];
    logic signed [W-1:0]    f0_reg;
    logic signed [W-1:0]    a1_reg [L];
    logic signed [W-1:0]    b1_reg [L];
    logic signed [W-1:0]    a2_reg [L];
    logic signed [W-1:0]    ma [L][L];
    logic signed [W-1:0]    mb [L][L];
    logic signed [2*W-1:0]  p1_next [L][L];
    logic signed [2*W-1:0]  p1_reg [L][L];
    logic signed [SW-1:0]   ham [L];
    logic signed [SW-1:0]   lane2_next [L];
    logic signed [SW-1:0]   lane2_reg [L];
    logic signed [SW-1:0]   d2_next;
    logic signed [SW-1:0]   d2_reg;
    logic signed [W-1:0]    r3_next [L];
    logic signed [W-1:0]    r3_reg [L];
    logic signed [W-1:0]    sc3_next, sc3_reg;
    logic [2*W-1:0]         ssq3_next, ssq3_reg;
    logic [W:0]             sat_lane [L];
    logic [W:0]             sat_dot;

    // Truncate the magnitude (optionally scaled down by F) and saturate.
    // Returns the overflow flag above the W result bits.
    function automatic logic [W:0] sat_val(input logic signed [SW-1:0] v, input logic sh);
        logic           neg;
        logic [SW-1:0]  mag;
        logic [SW-1:0]  lim;
        logic [W-1:0]   val;
        logic           o;
        neg = v[SW-1];
        mag = neg ? -v : v;
        if (sh)
        begin
            mag = mag >> F;
        end
        lim = neg ? (SW'(1) << (W - 1)) : ((SW'(1) << (W - 1)) - SW'(1));
        o = mag > lim;
        if (o)
        begin
            mag = lim;
        end
        val = mag[W-1:0];
        if (neg)
        begin
            val = -val;
        end
        return {o, val};
    endfunction

    // Input register.
    always_comb
    begin
        c0_next       = '0;
        c0_next.valid = accept;
        c0_next.op    = qau_pkg::op_t'(op);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= '0;
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else if (en)
        begin
            c0_reg <= c0_next;
            c1_reg <= c0_reg;
            c2_reg <= c1_reg;
            c3_reg <= c3_next;
        end
    end

    // Operand selection for the sixteen multipliers. Row zero doubles as the
    // dot product and the sum of squares; term zero of each row serves scale.
    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            for (int k = 0; k < L; k++)
            begin
                if (c0_reg.op == qau_pkg::OP_SCALE && k == 0)
                begin
                    ma[i][k] = a0_reg[i];
                    mb[i][k] = f0_reg;
                end
                else
                begin
                    ma[i][k] = a0_reg[k];
                    if (i == 0 && (c0_reg.op == qau_pkg::OP_NORM ||
                                   c0_reg.op == qau_pkg::OP_NORMZ ||
                                   c0_reg.op == qau_pkg::OP_INV))
                    begin
                        mb[i][k] = a0_reg[k];
                    end
                    else
                    begin
                        mb[i][k] = b0_reg[i ^ k];
                    end
                end
                p1_next[i][k] = ma[i][k] * mb[i][k];
            end
        end
    end

    // Sums of products and the component-wise operations.
    always_comb
    begin
        d2_next = '0;
        for (int k = 0; k < L; k++)
        begin
            d2_next = d2_next + SW'(p1_reg[0][k]);
        end
        for (int i = 0; i < L; i++)
        begin
            ham[i] = '0;
            for (int k = 0; k < L; k++)
            begin
                if (qau_pkg::HAM_MINUS[i*4+k])
                begin
                    ham[i] = ham[i] - SW'(p1_reg[i][k]);
                end
                else
                begin
                    ham[i] = ham[i] + SW'(p1_reg[i][k]);
                end
            end
            case (c1_reg.op)
                qau_pkg::OP_ADD:   lane2_next[i] = SW'(a1_reg[i]) + SW'(b1_reg[i]);
                qau_pkg::OP_SUB:   lane2_next[i] = SW'(a1_reg[i]) - SW'(b1_reg[i]);
                qau_pkg::OP_NEG:   lane2_next[i] = -SW'(a1_reg[i]);
                qau_pkg::OP_CONJ:  lane2_next[i] = (i == 0) ? SW'(a1_reg[i]) : -SW'(a1_reg[i]);
                qau_pkg::OP_SCALE: lane2_next[i] = SW'(p1_reg[i][0]);
                qau_pkg::OP_MUL:   lane2_next[i] = ham[i];
                default:           lane2_next[i] = '0;
            endcase
        end
    end

    // Scaling, saturation and result selection.
    always_comb
    begin
        c3_next   = c2_reg;
        sc3_next  = '0;
        ssq3_next = '0;
        for (int i = 0; i < L; i++)
        begin
            r3_next[i]  = '0;
            sat_lane[i] = sat_val(lane2_reg[i], c2_reg.op == qau_pkg::OP_SCALE ||
                                                c2_reg.op == qau_pkg::OP_MUL);
        end
        sat_dot = sat_val(d2_reg, 1'b1);
        case (c2_reg.op)
            qau_pkg::OP_ADD, qau_pkg::OP_SUB, qau_pkg::OP_NEG, qau_pkg::OP_CONJ,
            qau_pkg::OP_SCALE, qau_pkg::OP_MUL:
            begin
                for (int i = 0; i < L; i++)
                begin
                    r3_next[i]  = sat_lane[i][W-1:0];
                    c3_next.ovf = c3_next.ovf | sat_lane[i][W];
                end
            end
            qau_pkg::OP_DOT:
            begin
                sc3_next    = sat_dot[W-1:0];
                c3_next.ovf = sat_dot[W];
            end
            qau_pkg::OP_NORM, qau_pkg::OP_NORMZ, qau_pkg::OP_INV:
            begin
                r3_next   = a2_reg;
                ssq3_next = d2_reg[2*W] ? {(2*W){1'b1}} : d2_reg[2*W-1:0];
            end
            default:
            begin
                c3_next.ovf = 1'b0;
            end
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg    <= a;
            b0_reg    <= b;
            f0_reg    <= f;
            p1_reg    <= p1_next;
            a1_reg    <= a0_reg;
            b1_reg    <= b0_reg;
            lane2_reg <= lane2_next;
            d2_reg    <= d2_next;
            a2_reg    <= a1_reg;
            r3_reg    <= r3_next;
            sc3_reg   <= sc3_next;
            ssq3_reg  <= ssq3_next;
        end
    end

    assign ctrl = c3_reg;
    assign r    = r3_reg;
    assign sc   = sc3_reg;
    assign ssq  = ssq3_reg;

endmodule

`default_nettype wire

[rtl/core/qau_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module qau_sqrt_cell #(
    parameter int W = qau_pkg::COMPONENT_WIDTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [W:0]     rem_in,
    input  wire logic [W-1:0]   root_in,
    input  wire logic [2*W-1:0] rad_in,
    output logic [W:0]          rem_out,
    output logic [W-1:0]        root_out,
    output logic [2*W-1:0]      rad_out
);

    logic [W+2:0]   t;
    logic [W+2:0]   trial;
    logic [W+2:0]   diff;
    logic           ge;
    logic [W:0]     rem_reg, rem_next;
    logic [W-1:0]   root_reg, root_next;
    logic [2*W-1:0] rad_reg, rad_next;

    // One root bit per cell: bring down two radicand bits, try 4*root+1.
    always_comb
    begin
        t         = {rem_in, rad_in[2*W-1:2*W-2]};
        trial     = {1'b0, root_in, 2'b01};
        diff      = t - trial;
        ge        = t >= trial;
        rem_next  = ge ? diff[W:0] : t[W:0];
        root_next = {root_in[W-2:0], ge};
        rad_next  = {rad_in[2*W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;

endmodule

`default_nettype wire

[rtl/core/qau_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module qau_div_cell #(
    parameter int W = qau_pkg::COMPONENT_WIDTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [2*W-1:0] den_in,
    input  wire logic [2*W-1:0] rem_in [qau_pkg::LANES],
    input  wire logic [W-1:0]   nlo_in [qau_pkg::LANES],
    input  wire logic [W-1:0]   quo_in [qau_pkg::LANES],
    output logic [2*W-1:0]      den_out,
    output logic [2*W-1:0]      rem_out [qau_pkg::LANES],
    output logic [W-1:0]        nlo_out [qau_pkg::LANES],
    output logic [W-1:0]        quo_out [qau_pkg::LANES]
);

    localparam int L = qau_pkg::LANES;

    logic [2*W:0]   t [L];
    logic [2*W:0]   diff [L];
    logic [L-1:0]   ge;
    logic [2*W-1:0] den_reg;
    logic [2*W-1:0] rem_reg [L];
    logic [2*W-1:0] rem_next [L];
    logic [W-1:0]   nlo_reg [L];
    logic [W-1:0]   nlo_next [L];
    logic [W-1:0]   quo_reg [L];
    logic [W-1:0]   quo_next [L];

    // One restoring division step per lane; all lanes share the divisor.
    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            t[i]        = {rem_in[i], nlo_in[i][W-1]};
            diff[i]     = t[i] - {1'b0, den_in};
            ge[i]       = t[i] >= {1'b0, den_in};
            rem_next[i] = ge[i] ? diff[i][2*W-1:0] : t[i][2*W-1:0];
            quo_next[i] = {quo_in[i][W-2:0], ge[i]};
            nlo_next[i] = {nlo_in[i][W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_in;
            rem_reg <= rem_next;
            nlo_reg <= nlo_next;
            quo_reg <= quo_next;
        end
    end

    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign nlo_out = nlo_reg;
    assign quo_out = quo_reg;

endmodule

`default_nettype wire
